@@ hdl/kect_pkg.sv @@
// ----------------------------------------------------------------------------
// kect_pkg
// shared types, codes and sizes of the keyed epoch counter table
// ----------------------------------------------------------------------------
package kect_pkg;

  localparam int MaxEntries = 16;  // slots in the table, 1 to 1024
  localparam int KeyBits    = 64;  // key bits that take part, 8 to 64

  localparam int IdxW    = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW    = $clog2(MaxEntries + 1);
  localparam int EpochW  = 64;
  localparam int PaddrW  = 4;
  localparam int PdataW  = 64;

  // register index taken from the address (8 bytes per register)
  localparam logic [PaddrW-4:0] CfgInitEpoch = '0;
  localparam logic [EpochW-1:0] InitEpochRst = 64'd1;

  typedef enum logic [1:0] {
    KIND_REGISTER = 2'd0,
    KIND_GET      = 2'd1,
    KIND_BUMP     = 2'd2,
    KIND_SET      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [EpochW-1:0]   epoch;
  } res_t;

endpackage

@@ hdl/kect_if.sv @@
// ----------------------------------------------------------------------------
// kect_in_if / kect_out_if
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
interface kect_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] key;
  logic [63:0] new_epoch;

  modport source (output valid, output kind, output key, output new_epoch, input ready);
  modport sink   (input valid, input kind, input key, input new_epoch, output ready);
endinterface

interface kect_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] epoch_out;

  modport source (output valid, output status, output epoch_out, input ready);
  modport sink   (input valid, input status, input epoch_out, output ready);
endinterface

@@ hdl/keyed_epoch_counter_table_core.sv @@
// ----------------------------------------------------------------------------
// keyed_epoch_counter_table_core
// keyed table of 64-bit epoch counters with register, get, bump and set
// ----------------------------------------------------------------------------
// One item is handled at a time. An accepted item is searched slot by slot,
// from slot 0 until its key matches or the fill count is reached, then it
// waits in the response state until the output register takes its result,
// and only then is the next item accepted. The search is linear: the key
// ram gives one stored key per cycle through its single read port, whose
// read data is registered. Keys and epochs sit in two synchronous rams read
// at the same slot, so a hit already has its epoch in hand; the write-back
// lands on the cycle the result is handed to the output register, before
// the next item can start a search, so no forwarding is needed. No clearing
// pass runs after reset: only slots below the fill count are ever read.
module keyed_epoch_counter_table_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  kect_in_if.sink                     in_i,
  kect_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kect_pkg::PaddrW-1:0] paddr,
  input  logic [kect_pkg::PdataW-1:0] pwdata,
  output logic [kect_pkg::PdataW-1:0] prdata,
  output logic                        pready
);
  import kect_pkg::*;

  logic [EpochW-1:0] init_epoch;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  // output register, keeps the result while the sink stalls
  logic              out_valid_q;
  res_t              out_res_q;

  // configuration registers
  kect_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .init_epoch_o (init_epoch)
  );

  // search and read-modify-write engine with both rams
  kect_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .init_epoch_i (init_epoch),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // the engine may hand over a result when the register is empty or draining
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_res_q.status;
  assign out_o.epoch_out = out_res_q.epoch;

endmodule

@@ hdl/kect_ram.sv @@
// ----------------------------------------------------------------------------
// kect_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module kect_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/kect_cfg.sv @@
// ----------------------------------------------------------------------------
// kect_cfg
// apb register file holding the initial epoch for new keys
// ----------------------------------------------------------------------------
module kect_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kect_pkg::PaddrW-1:0]   paddr,
  input  logic [kect_pkg::PdataW-1:0]   pwdata,
  output logic [kect_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  output logic [kect_pkg::EpochW-1:0]   init_epoch_o
);
  import kect_pkg::*;

  logic [EpochW-1:0] init_epoch_q;
  logic              sel_init;

  assign sel_init = (paddr[PaddrW-1:3] == CfgInitEpoch);
  assign pready   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_epoch_q <= InitEpochRst;
    end else if (psel && penable && pwrite && sel_init) begin
      init_epoch_q <= pwdata;
    end
  end

  assign prdata       = sel_init ? init_epoch_q : '0;
  assign init_epoch_o = init_epoch_q;

endmodule

@@ hdl/kect_engine.sv @@
// ----------------------------------------------------------------------------
// kect_engine
// linear key search over the key ram, then read-modify-write of the epoch
// ----------------------------------------------------------------------------
module kect_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  kect_in_if.sink                     in_i,
  input  logic [kect_pkg::EpochW-1:0] init_epoch_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output kect_pkg::res_t              res_o
);
  import kect_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_RESP   = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic               hit_q, hit_d;
  logic [CntW-1:0]    used_q;
  kind_e              kind_q;
  logic [KeyBits-1:0] key_q;
  logic [EpochW-1:0]  ne_q;

  logic               accept;
  logic               fire;
  logic               re;
  logic [KeyBits-1:0] key_rdata;
  logic [EpochW-1:0]  ep_rdata;
  logic               key_we, ep_we;
  logic [IdxW-1:0]    waddr;
  logic [EpochW-1:0]  ep_wdata;
  logic [EpochW-1:0]  ep_inc;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && (state_q == ST_IDLE);
  assign fire       = (state_q == ST_RESP) && res_ready_i;
  assign ep_inc     = ep_rdata + EpochW'(1);

  // search sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    hit_d   = hit_q;
    re      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          idx_d = '0;
          if (used_q == '0) begin
            hit_d   = 1'b0;
            state_d = ST_RESP;
          end else begin
            re      = 1'b1;
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (key_rdata == key_q) begin
          hit_d   = 1'b1;
          state_d = ST_RESP;
        end else if (CntW'(idx_q) + CntW'(1) < used_q) begin
          idx_d = idx_q + IdxW'(1);
          re    = 1'b1;
        end else begin
          hit_d   = 1'b0;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result and write-back, writes land on the result handshake
  always_comb begin
    res_o.status = STATUS_OK;
    res_o.epoch  = '0;
    key_we       = 1'b0;
    ep_we        = 1'b0;
    waddr        = idx_q;
    ep_wdata     = ne_q;
    case (kind_q)
      KIND_REGISTER: begin
        if (!hit_q) begin
          if (used_q >= CntW'(MaxEntries)) begin
            res_o.status = STATUS_FULL;
          end else begin
            key_we   = 1'b1;
            ep_we    = 1'b1;
            waddr    = IdxW'(used_q);
            ep_wdata = init_epoch_i;
          end
        end
      end
      KIND_GET: begin
        if (hit_q) res_o.epoch = ep_rdata;
        else       res_o.status = STATUS_NOT_FOUND;
      end
      KIND_BUMP: begin
        if (hit_q) begin
          res_o.epoch = ep_inc;
          ep_we       = 1'b1;
          ep_wdata    = ep_inc;
        end else begin
          res_o.status = STATUS_NOT_FOUND;
        end
      end
      KIND_SET: begin
        if (hit_q) ep_we = 1'b1;
        else       res_o.status = STATUS_NOT_FOUND;
      end
      default: res_o.status = STATUS_NOT_FOUND;
    endcase
  end

  assign res_valid_o = (state_q == ST_RESP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      hit_q   <= 1'b0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      hit_q   <= hit_d;
      if (fire && key_we) begin
        used_q <= used_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_e'(in_i.kind);
      key_q  <= in_i.key[KeyBits-1:0];
      ne_q   <= in_i.new_epoch;
    end
  end

  kect_ram #(.Width(KeyBits), .Depth(MaxEntries)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (fire && key_we),
    .waddr_i (waddr),
    .wdata_i (key_q),
    .re_i    (re),
    .raddr_i (idx_d),
    .rdata_o (key_rdata)
  );

  kect_ram #(.Width(EpochW), .Depth(MaxEntries)) u_epoch_ram (
    .clk_i   (clk_i),
    .we_i    (fire && ep_we),
    .waddr_i (waddr),
    .wdata_i (ep_wdata),
    .re_i    (re),
    .raddr_i (idx_d),
    .rdata_o (ep_rdata)
  );

  // a new key is only appended below capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && key_we) |-> (used_q < CntW'(MaxEntries)))
    else $error("key appended to a full table");

  // the fill count moves by one per append and never otherwise
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> ($past(fire) && $past(key_we)
      && (used_q == $past(used_q) + CntW'(1))))
    else $error("fill count moved without an append");

  // the search never looks beyond the used slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (CntW'(idx_q) < used_q))
    else $error("search index beyond used slots");

  // an accepted item always leaves the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ((state_q == ST_SEARCH) || (state_q == ST_RESP)))
    else $error("accepted item not taken up");

endmodule

@@ tb/sv/keyed_epoch_counter_table_core_tb.sv @@
// ----------------------------------------------------------------------------
// keyed_epoch_counter_table_core_tb
// self-checking bench: register, get, bump and set items against a predictor
// of the epoch table, with random idling on both channels and with the
// reset value, the maximum, zero and random values for the initial epoch
// ----------------------------------------------------------------------------

// mirror of the table: predicts one result per request item and checks the
// results in order against what was predicted
class epoch_table_tracker;
  logic [63:0]      slot_key   [kect_pkg::MaxEntries];
  logic [63:0]      slot_epoch [kect_pkg::MaxEntries];
  int unsigned      fill;
  logic [63:0]      init_epoch;
  kect_pkg::res_t   expected_results [$];
  int unsigned      errors;

  function new();
    fill       = 0;
    init_epoch = kect_pkg::InitEpochRst;
    errors     = 0;
  endfunction

  function void set_initial_epoch(logic [63:0] value);
    init_epoch = value;
  endfunction

  function int unsigned pending();
    return expected_results.size();
  endfunction

  function void note_request(kect_pkg::kind_e kind, logic [63:0] key, logic [63:0] new_epoch);
    logic [63:0]    k;
    int             slot;
    kect_pkg::res_t res;
    k          = key & ({64{1'b1}} >> (64 - kect_pkg::KeyBits));
    slot       = -1;
    res.status = kect_pkg::STATUS_OK;
    res.epoch  = '0;
    for (int i = 0; i < fill; i++)
      if (slot < 0 && slot_key[i] == k) slot = i;
    case (kind)
      kect_pkg::KIND_REGISTER: begin
        if (slot < 0) begin
          if (fill >= kect_pkg::MaxEntries) begin
            res.status = kect_pkg::STATUS_FULL;
          end else begin
            slot_key[fill]   = k;
            slot_epoch[fill] = init_epoch;
            fill++;
          end
        end
      end
      kect_pkg::KIND_GET: begin
        if (slot < 0) res.status = kect_pkg::STATUS_NOT_FOUND;
        else res.epoch = slot_epoch[slot];
      end
      kect_pkg::KIND_BUMP: begin
        if (slot < 0) begin
          res.status = kect_pkg::STATUS_NOT_FOUND;
        end else begin
          slot_epoch[slot] = slot_epoch[slot] + 64'd1;
          res.epoch        = slot_epoch[slot];
        end
      end
      default: begin
        if (slot < 0) res.status = kect_pkg::STATUS_NOT_FOUND;
        else slot_epoch[slot] = new_epoch;
      end
    endcase
    expected_results.push_back(res);
  endfunction

  function void check_result(logic [1:0] status, logic [63:0] epoch);
    kect_pkg::res_t want;
    if (expected_results.size() == 0) begin
      $error("result with nothing outstanding: status %0d epoch_out %h", status, epoch);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    if (status !== want.status) begin
      $error("status mismatch: expected %0d, actual %0d", want.status, status);
      errors++;
    end
    if (epoch !== want.epoch) begin
      $error("epoch_out mismatch: expected %h, actual %h", want.epoch, epoch);
      errors++;
    end
  endfunction
endclass

module keyed_epoch_counter_table_core_tb;
  import kect_pkg::*;

  localparam int RandomPerPhase = 510;
  localparam int HoldCycles     = 400;              // long receiver hold-off
  localparam int TailCycles     = 2 * (MaxEntries + 3);
  localparam int QuietLimit     = 4000;             // cycles with nothing moving

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  kect_in_if  req_if ();
  kect_out_if res_if ();

  epoch_table_tracker tracker = new();

  // idling odds in percent, changed per phase by the stimulus
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  int unsigned quiet_cycles  = 0;

  always #4 clk_i = ~clk_i;

  keyed_epoch_counter_table_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // epoch values lean towards the top of the range so that bumps wrap
  function automatic logic [63:0] pick_epoch();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return 64'hFFFF_FFFF_FFFF_FFFE;
      2:       return '0;
      default: return rand64();
    endcase
  endfunction

  // mostly keys already in the table; registers take a fresh key only at the
  // given odds so that the table fills slowly across the phases
  function automatic logic [63:0] pick_key(kind_e kind, int unsigned fresh_pct);
    int unsigned roll;
    bit          fresh;
    logic [63:0] k;
    roll = $urandom_range(0, 99);
    if (kind == KIND_REGISTER) fresh = (roll < fresh_pct);
    else fresh = (roll < 15);
    if (tracker.fill == 0 || fresh) begin
      case ($urandom_range(0, 15))
        0:       k = '0;
        1:       k = '1;
        default: k = rand64();
      endcase
    end else begin
      k = tracker.slot_key[$urandom_range(0, tracker.fill - 1)];
      // near miss: one bit away from a stored key
      if (kind != KIND_REGISTER && $urandom_range(0, 9) == 0)
        k = k ^ (64'd1 << $urandom_range(0, 63));
    end
    return k;
  endfunction

  // offer one item and hold it until the block takes it; valid is left high
  // so that back-to-back items need no second assignment in one step
  task automatic send_item(kind_e kind, logic [63:0] key, logic [63:0] new_epoch);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.kind      <= kind;
    req_if.key       <= key;
    req_if.new_epoch <= new_epoch;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    tracker.note_request(kind, key, new_epoch);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // setup cycle, then access cycle; the register takes the value at the edge
  // where the access completes
  task automatic write_initial_epoch(logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {CfgInitEpoch, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_initial_epoch(value);
  endtask

  task automatic random_phase(int unsigned send_pct, int unsigned recv_pct,
                              int unsigned fresh_pct, logic [63:0] init_value,
                              bit with_hold);
    kind_e kind;
    wait_for_results();
    write_initial_epoch(init_value);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < RandomPerPhase; n++) begin
      // receiver backs off for a long stretch while items keep coming
      if (with_hold && n == RandomPerPhase / 3) hold_req = 1'b1;
      kind = kind_e'($urandom_range(0, 3));
      send_item(kind, pick_key(kind, fresh_pct), pick_epoch());
    end
  endtask

  // result side: check at each edge where an item leaves, then pick the
  // ready for the next cycle; during a hold-off ready stays low, then is picked anew
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready)
        tracker.check_result(res_if.status, res_if.epoch_out);
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog: a run where nothing moves for too long is a hang
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    req_if.valid     <= 1'b0;
    req_if.kind      <= KIND_REGISTER;
    req_if.key       <= '0;
    req_if.new_epoch <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, initial epoch still at its reset value
    // empty table: every lookup misses
    send_item(KIND_GET, '0, rand64());
    send_item(KIND_BUMP, '0, rand64());
    send_item(KIND_SET, '0, '1);
    // first key, then the same key again, which leaves it untouched
    send_item(KIND_REGISTER, '0, rand64());
    send_item(KIND_REGISTER, '0, rand64());
    send_item(KIND_GET, '0, rand64());
    send_item(KIND_BUMP, '0, rand64());
    // set to the top of the range, then bump wraps to zero
    send_item(KIND_SET, '0, '1);
    send_item(KIND_GET, '0, rand64());
    send_item(KIND_BUMP, '0, rand64());
    send_item(KIND_REGISTER, '1, rand64());
    // absent key one bit away from a stored one
    send_item(KIND_GET, 64'd1, rand64());

    // initial epoch at its maximum: a bump on a fresh key wraps at once
    wait_for_results();
    write_initial_epoch('1);
    send_item(KIND_REGISTER, 64'hAAAA_AAAA_AAAA_AAAA, rand64());
    send_item(KIND_BUMP, 64'hAAAA_AAAA_AAAA_AAAA, rand64());
    send_item(KIND_GET, 64'hAAAA_AAAA_AAAA_AAAA, rand64());

    // initial epoch at zero
    wait_for_results();
    write_initial_epoch('0);
    send_item(KIND_REGISTER, 64'h5555_5555_5555_5555, rand64());
    send_item(KIND_GET, 64'h5555_5555_5555_5555, rand64());
    send_item(KIND_SET, '1, 64'h8000_0000_0000_0000);
    send_item(KIND_BUMP, '1, rand64());
    send_item(KIND_GET, '1, rand64());

    // random part: receiver idles more, then sender, then neither; the last
    // phase takes fresh keys more often so the table runs full
    random_phase(38, 45, 3, rand64(), 1'b1);
    random_phase(45, 38, 3, '1, 1'b0);
    random_phase(0, 0, 20, rand64(), 1'b0);

    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ keyed_epoch_counter_table_core.f @@
hdl/kect_pkg.sv
hdl/kect_if.sv
hdl/kect_ram.sv
hdl/kect_cfg.sv
hdl/kect_engine.sv
hdl/keyed_epoch_counter_table_core.sv
tb/sv/keyed_epoch_counter_table_core_tb.sv
